// ===== rtl/cdl_pkg.sv =====
// cdl_pkg: shared types, codes and constants of the checkpoint digest ledger.
// No dependencies.
`timescale 1ns / 1ps
package cdl_pkg;

  localparam int unsigned DEFAULT_RING_DEPTH = 1024;

  localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;
  localparam logic [19:0] NS_PER_SEQ = 20'd1000000;

  // operation codes (tuser)
  localparam logic [2:0] OP_MIX_WORD = 3'd0;
  localparam logic [2:0] OP_REF_BYTE = 3'd1;
  localparam logic [2:0] OP_REF_END  = 3'd2;
  localparam logic [2:0] OP_SEAL     = 3'd3;
  localparam logic [2:0] OP_LOOKUP   = 3'd4;
  localparam logic [2:0] OP_CLEAR    = 3'd5;

  // configuration register indexes
  localparam logic CFG_MAX_HELD      = 1'b0;
  localparam logic CFG_CHECK_SESSION = 1'b1;

  localparam logic [10:0] MAX_HELD_RESET = 11'd1024;

  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned OUT_DATA_W = 184;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] session;
    logic [15:0] legs;
    logic [31:0] digest;
    logic        valid;
  } rec_t;

  // controller -> datapath
  typedef struct packed {
    logic fold_word;  // op 0
    logic fold_byte;  // op 1
    logic ref_end;    // op 2
    logic clear;      // op 5
    logic load;       // capture seal/lookup item, issue ring read
    logic seal;       // with load: the item is a seal, else a lookup
    logic finish;     // complete seal/lookup, load output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } stat_t;

  function automatic logic [31:0] fnv_fold(input logic [31:0] h, input logic [31:0] v);
    return (h ^ v) * FNV_PRIME;
  endfunction

endpackage

// ===== rtl/cdl_ctrl.sv =====
// cdl_ctrl: sequencing state machine of the ledger.
// Depends on cdl_pkg.
`timescale 1ns / 1ps
module cdl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [2:0]      s_tuser,
  input  cdl_pkg::stat_t  stat,
  output cdl_pkg::cmd_t   cmd
);
  import cdl_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic take;

  assign s_tready = (state == ST_IDLE);
  assign take     = s_tvalid && s_tready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take) begin
          case (s_tuser)
            OP_MIX_WORD: cmd.fold_word = 1'b1;
            OP_REF_BYTE: cmd.fold_byte = 1'b1;
            OP_REF_END:  cmd.ref_end   = 1'b1;
            OP_CLEAR:    cmd.clear     = 1'b1;
            OP_SEAL: begin
              cmd.load   = 1'b1;
              cmd.seal   = 1'b1;
              state_next = ST_EXEC;
            end
            OP_LOOKUP: begin
              cmd.load   = 1'b1;
              state_next = ST_EXEC;
            end
            default: ;
          endcase
        end
      end
      ST_EXEC: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

endmodule

// ===== rtl/cdl_dp.sv =====
// cdl_dp: digest accumulators, record ring memory, ring bookkeeping and
// output register. Depends on cdl_pkg.
`timescale 1ns / 1ps
module cdl_dp #(
  parameter int unsigned RING_DEPTH = cdl_pkg::DEFAULT_RING_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  cdl_pkg::cmd_t                   cmd,
  output cdl_pkg::stat_t                  stat,
  input  logic [cdl_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [10:0]                     cfg_data,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [cdl_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import cdl_pkg::*;

  localparam int unsigned SW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam logic [SW:0]   DEPTH_S = (SW + 1)'(RING_DEPTH);
  localparam logic [31:0]   DEPTH_32 = 32'(RING_DEPTH);

  // input fields
  logic [31:0] in_word, in_session, in_lookup;
  logic [7:0]  in_byte;
  logic [15:0] in_legs;
  assign in_word    = s_tdata[31:0];
  assign in_byte    = s_tdata[39:32];
  assign in_session = s_tdata[71:40];
  assign in_legs    = s_tdata[87:72];
  assign in_lookup  = s_tdata[119:88];

  // config
  logic [10:0] max_held;
  logic        check_session;

  // state
  logic [31:0]   digest_acc, byte_acc, latest_seq, last_session;
  logic          byte_seen;
  logic [CW-1:0] held_count, invalid_count;
  logic [SW-1:0] oldest_slot;

  rec_t mem [RING_DEPTH];
  rec_t rd_rec;

  // captured item
  logic        is_seal, hit;
  logic [31:0] cap_session;
  logic [15:0] cap_legs;

  // output register
  logic [OUT_DATA_W-1:0] out_data;

  assign stat.out_free = !m_tvalid || m_tready;

  // lookup address: held seqs are consecutive, oldest first
  logic [31:0] oldest_seq, lk_off;
  logic        lk_hit;
  logic [SW:0] lk_sum, lk_slot;
  logic [SW-1:0] rd_addr;
  assign oldest_seq = latest_seq - 32'(held_count) + 32'd1;
  assign lk_off     = in_lookup - oldest_seq;
  assign lk_hit     = lk_off < 32'(held_count);
  assign lk_sum     = (SW + 1)'(oldest_slot) + (SW + 1)'(lk_off[SW-1:0]);
  assign lk_slot    = (lk_sum >= DEPTH_S) ? lk_sum - DEPTH_S : lk_sum;
  // a seal reads the oldest record to see whether an eviction drops an invalid one
  assign rd_addr    = cmd.seal ? oldest_slot : lk_slot[SW-1:0];

  // seal evaluation
  logic [31:0] limit;
  logic        evict;
  logic [CW-1:0] held_after_evict, held_new, inv_after_evict, inv_new;
  logic [SW:0]   ws_sum, oldest_inc;
  logic [SW-1:0] write_slot, oldest_new;
  logic          new_valid;
  logic [31:0]   new_seq;
  rec_t          new_rec, res_rec;
  logic [51:0]   ns;

  always_comb begin
    if (max_held == 11'd0)              limit = 32'd1;
    else if (32'(max_held) > DEPTH_32)  limit = DEPTH_32;
    else                                limit = 32'(max_held);
  end

  assign evict            = 32'(held_count) >= limit;
  assign held_after_evict = evict ? held_count - CW'(1) : held_count;
  assign held_new         = held_after_evict + CW'(1);
  assign oldest_inc       = (SW + 1)'(oldest_slot) + (SW + 1)'(1);
  assign oldest_new       = evict ? ((oldest_inc >= DEPTH_S) ? SW'(0) : oldest_inc[SW-1:0])
                                  : oldest_slot;
  assign ws_sum           = (SW + 1)'(oldest_slot) + (SW + 1)'(held_count);
  assign write_slot       = (ws_sum >= DEPTH_S) ? SW'(ws_sum - DEPTH_S) : ws_sum[SW-1:0];
  assign new_seq          = latest_seq + 32'd1;
  // previous record is the newest one; it is gone only if the ring empties
  assign new_valid = !(check_session && latest_seq != 32'd0 &&
                       held_after_evict != CW'(0) && last_session != 32'd0 &&
                       last_session != cap_session);
  assign inv_after_evict = (evict && !rd_rec.valid && invalid_count != CW'(0))
                         ? invalid_count - CW'(1) : invalid_count;
  assign inv_new = new_valid ? inv_after_evict : inv_after_evict + CW'(1);

  always_comb begin
    new_rec.seq     = new_seq;
    new_rec.session = cap_session;
    new_rec.legs    = cap_legs;
    new_rec.digest  = digest_acc;
    new_rec.valid   = new_valid;
  end

  assign res_rec = is_seal ? new_rec : (hit ? rd_rec : '0);
  assign ns      = {20'd0, res_rec.seq} * {32'd0, NS_PER_SEQ};

  always_comb begin
    logic ok;
    logic [CW-1:0] held_o;
    ok     = is_seal ? (inv_new == CW'(0)) : (invalid_count == CW'(0));
    held_o = is_seal ? held_new : held_count;
    out_data          = '0;
    out_data[31:0]    = res_rec.seq;
    out_data[63:32]   = res_rec.digest;
    out_data[64]      = ok;
    out_data[65]      = !ok;
    out_data[66]      = !is_seal && hit;
    out_data[98:67]   = is_seal ? 32'd0 : res_rec.session;
    out_data[114:99]  = is_seal ? 16'd0 : res_rec.legs;
    out_data[115]     = res_rec.valid;
    out_data[167:116] = ns;
    out_data[178:168] = 11'(held_o);
  end

  // ring memory
  always_ff @(posedge clk) begin
    if (cmd.finish && is_seal) mem[write_slot] <= new_rec;
    if (cmd.load)              rd_rec <= mem[rd_addr];
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_seal     <= cmd.seal;
      hit         <= lk_hit;
      cap_session <= in_session;
      cap_legs    <= in_legs;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_held      <= MAX_HELD_RESET;
      check_session <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_HELD:      max_held      <= cfg_data;
        CFG_CHECK_SESSION: check_session <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // digest and ring bookkeeping
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      digest_acc    <= FNV_BASIS;
      byte_acc      <= FNV_BASIS;
      byte_seen     <= 1'b0;
      latest_seq    <= '0;
      held_count    <= '0;
      oldest_slot   <= '0;
      invalid_count <= '0;
      if (rst) last_session <= '0;
    end else begin
      if (cmd.fold_word) digest_acc <= fnv_fold(digest_acc, in_word);
      if (cmd.fold_byte) begin
        byte_acc  <= fnv_fold(byte_acc, {24'd0, in_byte});
        byte_seen <= 1'b1;
      end
      if (cmd.ref_end) begin
        if (byte_seen) digest_acc <= fnv_fold(digest_acc, byte_acc);
        byte_acc  <= FNV_BASIS;
        byte_seen <= 1'b0;
      end
      if (cmd.finish && is_seal) begin
        held_count    <= held_new;
        oldest_slot   <= oldest_new;
        invalid_count <= inv_new;
        latest_seq    <= new_seq;
        last_session  <= cap_session;
        digest_acc    <= FNV_BASIS;
        byte_acc      <= FNV_BASIS;
        byte_seen     <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) m_tdata <= out_data;
  end

endmodule

// ===== rtl/checkpoint_digest_ledger.sv =====
// checkpoint_digest_ledger: top level, joins controller and datapath.
// Depends on cdl_pkg, cdl_ctrl, cdl_dp.
`timescale 1ns / 1ps
// Word-wise FNV-1a frame digest with a ring log of sealed checkpoint records.
// Items arrive on the s_ side; tuser carries the operation (0 mix word,
// 1 reference byte, 2 reference end, 3 seal, 4 lookup, 5 clear). Mix, byte,
// reference end and clear give no result. For a seal or lookup, the accept
// cycle reads the record ring (one synchronous read port) into a register;
// the EXEC state then finishes the seal or lookup and loads the output
// register, waiting while the output register is full and not taken.
// s_tready stays low until then, so no new item is taken meanwhile. The
// ring is not cleared after reset: only data of held slots is ever used.
module checkpoint_digest_ledger #(
  parameter int unsigned RING_DEPTH = cdl_pkg::DEFAULT_RING_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  // tdata: word_value[31:0], ref_byte[39:32], session[71:40],
  //        legs[87:72], lookup_seq[119:88]
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [cdl_pkg::IN_DATA_W-1:0]   s_tdata,
  // tuser: operation[2:0]
  input  logic [2:0]                      s_tuser,
  // tdata: seq_no[31:0], digest[63:32], chain_ok[64],
  //        status[65], found[66], session_out[98:67], legs_out[114:99],
  //        record_valid[115], stamp_ns[167:116], records_held[178:168]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [cdl_pkg::OUT_DATA_W-1:0]  m_tdata,
  // config: index 0 max_held, 1 check_session
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [10:0]                     cfg_data
);
  import cdl_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  cdl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .stat     (stat),
    .cmd      (cmd)
  );

  cdl_dp #(.RING_DEPTH(RING_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
